FILE: sv/ccidx_pkg.sv
// ----------------------------------------------------------------------------
// Commodity channel index package
// Shared widths, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package ccidx_pkg;

  localparam int unsigned PRICE_W     = 32;
  localparam int unsigned TP_W        = 34;
  localparam int unsigned FACTOR_W    = 16;
  localparam int unsigned FACTOR_FRAC = 16;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CCI_W       = 32;
  localparam int unsigned WLEN_W      = 9;

  localparam logic CFG_WINDOW_LENGTH = 1'b0;
  localparam logic CFG_CCI_FACTOR    = 1'b1;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd983;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_DEV,
    S_MD_GO,
    S_MD_WAIT,
    S_MUL,
    S_CCI_GO,
    S_CCI_WAIT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: sv/commodity_channel_index.sv
// ----------------------------------------------------------------------------
// Commodity channel index
// Sliding-window CCI over price bars, built on a rotating chain of cells.
// ----------------------------------------------------------------------------
// Each word is one bar, and each bar gives one result word. A valid bar shifts
// high+low+close into a chain of WINDOW_MAX cells. Once window_length bars are
// held, the chain is rotated through once to form the sum and once more for
// the absolute deviation. One shared restoring divider forms the mean, the
// mean deviation and the final quotient; at the defaults its width DW is
// 34 + FRAC_BITS + 16 = 66. A zero mean deviation skips the last division.
// Invalid and warm-up bars go straight to the done state and skip the
// rotations and the divider. The next bar is taken in the cycle after the
// result word is loaded. A stalled output word keeps the next result in the
// done state, which holds the input off, until the word is taken. Writing
// window_length clears the window. Input is taken only while no bar is in
// progress.
`default_nettype none

module commodity_channel_index #(
  parameter int unsigned WINDOW_MAX = 256,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic                              cfg_index,
  input  wire logic [ccidx_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ccidx_pkg::PRICE_W-1:0]     high_price,
  input  wire logic [ccidx_pkg::PRICE_W-1:0]     low_price,
  input  wire logic [ccidx_pkg::PRICE_W-1:0]     close_price,
  input  wire logic                              bar_valid,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [ccidx_pkg::CCI_W-1:0]     index_value,
  output logic                                   cci_valid
);

  localparam int unsigned TP_W      = ccidx_pkg::TP_W;
  localparam int unsigned LW        = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SW        = TP_W + $clog2(WINDOW_MAX);
  localparam int unsigned SHIFT     = FRAC_BITS + ccidx_pkg::FACTOR_FRAC;
  localparam int unsigned NW        = TP_W + SHIFT;
  localparam int unsigned DW        = (NW > SW) ? NW : SW;
  localparam int unsigned VW        = ccidx_pkg::FACTOR_W + TP_W;
  localparam int unsigned LEN_RESET = (WINDOW_MAX < 20) ? WINDOW_MAX : 20;

  ccidx_pkg::state_t state, state_next;

  logic [LW-1:0]                      len;
  logic [ccidx_pkg::FACTOR_W-1:0]     factor;
  logic [LW-1:0]                      fill;
  logic [LW-1:0]                      fill_next;
  logic [LW-1:0]                      cnt;
  logic [SW-1:0]                      acc;
  logic [TP_W-1:0]                    tp_r;
  logic [TP_W-1:0]                    mean;
  logic [TP_W-1:0]                    md;
  logic [VW-1:0]                      den;
  logic [ccidx_pkg::CCI_W-1:0]        res_value;
  logic                               res_ok;

  logic                               accept;
  logic                               load;
  logic                               last;
  logic                               live;
  logic                               shift;
  logic [TP_W-1:0]                    tp_in;
  logic [TP_W-1:0]                    head;
  logic [TP_W-1:0]                    tail;
  logic [TP_W-1:0]                    tail_dev;
  logic [TP_W-1:0]                    abs_diff;
  logic                               neg;
  logic [31:0]                        wl_raw;
  logic [31:0]                        wl_clamp;
  logic [ccidx_pkg::CCI_W-1:0]        mag;
  logic [ccidx_pkg::CCI_W-1:0]        cci_res;

  logic                               div_start;
  logic [DW-1:0]                      div_dividend;
  logic [VW-1:0]                      div_divisor;
  logic [DW-1:0]                      div_quotient;
  logic                               div_done;

  logic [TP_W-1:0] tap [WINDOW_MAX];

  assign tp_in = TP_W'(high_price) + TP_W'(low_price) + TP_W'(close_price);
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != ccidx_pkg::S_IDLE);
  assign load = (state == ccidx_pkg::S_DONE) && (!out_valid || !out_stall);
  assign fill_next = (fill < len) ? fill + LW'(1) : fill;
  assign last = (cnt == LW'(WINDOW_MAX - 1));
  assign live = (32'(cnt) + 32'(len)) >= 32'(WINDOW_MAX);

  assign tail = tap[WINDOW_MAX-1];
  assign head = (state == ccidx_pkg::S_IDLE) ? tp_in : tail;
  assign shift = (accept && bar_valid) || (state == ccidx_pkg::S_SUM) ||
                 (state == ccidx_pkg::S_DEV);
  assign tail_dev = (tail >= mean) ? tail - mean : mean - tail;

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_chain
      if (gi == 0) begin : g_head
        ccidx_cell #(.W(TP_W)) u_cell (
          .clk   (clk),
          .shift (shift),
          .din   (head),
          .dout  (tap[gi])
        );
      end else begin : g_body
        ccidx_cell #(.W(TP_W)) u_cell (
          .clk   (clk),
          .shift (shift),
          .din   (tap[gi-1]),
          .dout  (tap[gi])
        );
      end
    end
  endgenerate

  assign neg = tp_r < mean;
  assign abs_diff = neg ? mean - tp_r : tp_r - mean;

  always_comb begin
    if (neg) begin
      mag = (div_quotient > DW'(33'h080000000)) ? 32'h80000000 :
            div_quotient[ccidx_pkg::CCI_W-1:0];
      cci_res = ccidx_pkg::CCI_W'(0) - mag;
    end else begin
      mag = (div_quotient > DW'(33'h07FFFFFFF)) ? 32'h7FFFFFFF :
            div_quotient[ccidx_pkg::CCI_W-1:0];
      cci_res = mag;
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DW'(acc);
    div_divisor  = VW'(len);
    case (state)
      ccidx_pkg::S_MEAN_GO: begin
        div_start = 1'b1;
      end
      ccidx_pkg::S_MD_GO: begin
        div_start = 1'b1;
      end
      ccidx_pkg::S_CCI_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'({abs_diff, {SHIFT{1'b0}}});
        div_divisor  = den;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  ccidx_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  always_comb begin
    state_next = state;
    case (state)
      ccidx_pkg::S_IDLE: begin
        if (accept) begin
          if (!bar_valid || (fill_next < len)) begin
            state_next = ccidx_pkg::S_DONE;
          end else begin
            state_next = ccidx_pkg::S_SUM;
          end
        end
      end
      ccidx_pkg::S_SUM: begin
        if (last) begin
          state_next = ccidx_pkg::S_MEAN_GO;
        end
      end
      ccidx_pkg::S_MEAN_GO: begin
        state_next = ccidx_pkg::S_MEAN_WAIT;
      end
      ccidx_pkg::S_MEAN_WAIT: begin
        if (div_done) begin
          state_next = ccidx_pkg::S_DEV;
        end
      end
      ccidx_pkg::S_DEV: begin
        if (last) begin
          state_next = ccidx_pkg::S_MD_GO;
        end
      end
      ccidx_pkg::S_MD_GO: begin
        state_next = ccidx_pkg::S_MD_WAIT;
      end
      ccidx_pkg::S_MD_WAIT: begin
        if (div_done) begin
          if (div_quotient[TP_W-1:0] == '0) begin
            state_next = ccidx_pkg::S_DONE;
          end else begin
            state_next = ccidx_pkg::S_MUL;
          end
        end
      end
      ccidx_pkg::S_MUL: begin
        state_next = ccidx_pkg::S_CCI_GO;
      end
      ccidx_pkg::S_CCI_GO: begin
        state_next = ccidx_pkg::S_CCI_WAIT;
      end
      ccidx_pkg::S_CCI_WAIT: begin
        if (div_done) begin
          state_next = ccidx_pkg::S_DONE;
        end
      end
      ccidx_pkg::S_DONE: begin
        if (load) begin
          state_next = ccidx_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ccidx_pkg::S_IDLE;
      end
    endcase
  end

  assign wl_raw = 32'(cfg_data[ccidx_pkg::WLEN_W-1:0]);
  assign wl_clamp = (wl_raw == 32'd0) ? 32'd1 :
                    (wl_raw > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX) : wl_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ccidx_pkg::S_IDLE;
      len       <= LW'(LEN_RESET);
      factor    <= ccidx_pkg::FACTOR_RESET;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == ccidx_pkg::CFG_WINDOW_LENGTH) begin
          len  <= LW'(wl_clamp);
          fill <= '0;
        end else begin
          factor <= (cfg_data == '0) ? ccidx_pkg::FACTOR_W'(1) : cfg_data;
        end
      end else if (accept && bar_valid) begin
        fill <= fill_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ccidx_pkg::S_IDLE: begin
        tp_r      <= tp_in;
        acc       <= '0;
        cnt       <= '0;
        res_value <= '0;
        res_ok    <= 1'b0;
      end
      ccidx_pkg::S_SUM: begin
        acc <= live ? acc + SW'(tail) : acc;
        cnt <= last ? '0 : cnt + LW'(1);
      end
      ccidx_pkg::S_MEAN_WAIT: begin
        if (div_done) begin
          mean <= div_quotient[TP_W-1:0];
          acc  <= '0;
        end
      end
      ccidx_pkg::S_DEV: begin
        acc <= live ? acc + SW'(tail_dev) : acc;
        cnt <= last ? '0 : cnt + LW'(1);
      end
      ccidx_pkg::S_MD_WAIT: begin
        if (div_done) begin
          md     <= div_quotient[TP_W-1:0];
          res_ok <= 1'b1;
        end
      end
      ccidx_pkg::S_MUL: begin
        den <= VW'(factor) * VW'(md);
      end
      ccidx_pkg::S_CCI_WAIT: begin
        if (div_done) begin
          res_value <= cci_res;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
    if (load) begin
      index_value <= res_value;
      cci_valid   <= res_ok;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ccidx_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// One stage of the typical-price chain; takes its neighbour's value on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ccidx_cell #(
  parameter int unsigned W = 34
) (
  input  wire logic         clk,
  input  wire logic         shift,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);

  logic [W-1:0] val;

  always_ff @(posedge clk) begin
    if (shift) begin
      val <= din;
    end
  end

  assign dout = val;

endmodule

`default_nettype wire

FILE: sv/ccidx_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle; done pulses when the quotient is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module ccidx_div #(
  parameter int unsigned DW = 66,
  parameter int unsigned VW = 50
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic      [DW-1:0] quotient,
  output logic               done
);

  localparam int unsigned CNT_W = $clog2(DW);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [VW-1:0]    rem;
  logic [DW-1:0]    quo;
  logic [VW-1:0]    dvs;
  logic [VW:0]      trial;
  logic             ge;

  assign trial = {rem, quo[DW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (run) begin
      rem <= ge ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
      quo <= {quo[DW-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

FILE: sv/ccidx_check.sv
// ----------------------------------------------------------------------------
// Commodity channel index checker
// Port-level properties of the index block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ccidx_check (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [ccidx_pkg::CCI_W-1:0]   index_value,
  input wire logic                          cci_valid
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled while a bar is in progress");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cci_valid) |-> (index_value == '0))
    else $error("invalid result carries a nonzero value");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled output word dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(index_value) && $stable(cci_valid)))
    else $error("stalled output word changed");

endmodule

bind commodity_channel_index ccidx_check u_ccidx_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .index_value (index_value),
  .cci_valid   (cci_valid)
);

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Commodity channel index testbench
// Drives price bars through the block with random idling on both sides.
// A behavioural predictor of the sliding window is run in step with the
// input. Each result word is checked, field by field, against the oldest
// prediction. A directed table runs first, then random phases that each
// write both registers, including out-of-range and extreme values.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int unsigned WMAX = 256;
  localparam int unsigned NPHASE = 6;
  localparam int unsigned EXP_DEPTH = 64;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic signed [ccidx_pkg::CCI_W-1:0] value;
    logic                               ok;
  } cci_t;

  typedef struct packed {
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] cl;
    logic        bv;
    logic        typed;
    logic [31:0] ev;
    logic        eok;
  } bar_row_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_write;
  logic                                cfg_index;
  logic [ccidx_pkg::CFG_W-1:0]         cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic [ccidx_pkg::PRICE_W-1:0]       high_price;
  logic [ccidx_pkg::PRICE_W-1:0]       low_price;
  logic [ccidx_pkg::PRICE_W-1:0]       close_price;
  logic                                bar_valid;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [ccidx_pkg::CCI_W-1:0]  index_value;
  logic                                cci_valid;

  commodity_channel_index DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .high_price(high_price), .low_price(low_price), .close_price(close_price),
    .bar_valid(bar_valid),
    .out_valid(out_valid), .out_stall(out_stall),
    .index_value(index_value), .cci_valid(cci_valid)
  );

  // Predictor state.
  logic [ccidx_pkg::TP_W-1:0] tp_win [WMAX];
  logic [41:0]     win_sum;
  int unsigned     fill_cnt;
  int unsigned     slot;
  int unsigned     wlen;
  int unsigned     factor;

  cci_t        exp_fifo [EXP_DEPTH];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int     errors = 0;
  int     results = 0;
  int     valid_results = 0;
  int     saturated = 0;
  longint cycles = 0;
  bit     sending_done = 0;

  bar_row_t dir_tab [25] = '{
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b1, 32'd0, 1'b0},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h80000000, 32'h00000001, 32'h7FFFFFFF, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h00001000, 32'h00000F00, 32'h00000F80, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h00001010, 32'h00000F10, 32'h00000F90, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h00000000, 32'h00000000, 32'h00000000, 1'b0, 1'b1, 32'd0, 1'b0},
    '{32'h00001020, 32'h00000F20, 32'h00000FA0, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h00001030, 32'h00000F30, 32'h00000FB0, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h00001040, 32'h00000F40, 32'h00000FC0, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h00001050, 32'h00000F50, 32'h00000FD0, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h00001060, 32'h00000F60, 32'h00000FE0, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h00001070, 32'h00000F70, 32'h00000FF0, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h00001080, 32'h00000F80, 32'h00001000, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h00001090, 32'h00000F90, 32'h00001010, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h000010A0, 32'h00000FA0, 32'h00001020, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h000010B0, 32'h00000FB0, 32'h00001030, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h000010C0, 32'h00000FC0, 32'h00001040, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h000010D0, 32'h00000FD0, 32'h00001050, 1'b1, 1'b1, 32'd0, 1'b0},
    '{32'h000010E0, 32'h00000FE0, 32'h00001060, 1'b1, 1'b0, 32'd0, 1'b0},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, 32'd0, 1'b0},
    '{32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 1'b0, 1'b1, 32'd0, 1'b0},
    '{32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 1'b0, 32'd0, 1'b0}
  };

  int unsigned ph_wlen [NPHASE] = '{0, 2, 7, 300, 3, 256};
  int unsigned ph_fac  [NPHASE] = '{983, 65535, 0, 983, 1, 40000};
  int unsigned ph_cnt  [NPHASE] = '{150, 250, 250, 450, 200, 350};

  function automatic cci_t predict_cci(input logic [31:0] hi, input logic [31:0] lo,
                                       input logic [31:0] cl, input logic bv);
    cci_t          r;
    logic [ccidx_pkg::TP_W-1:0] tp;
    logic [41:0]   mean;
    logic [41:0]   w;
    logic [63:0]   dsum;
    logic [63:0]   md;
    logic [127:0]  num;
    logic [127:0]  den;
    logic [127:0]  q;
    r = '0;
    if (!bv) return r;
    tp = {2'b00, hi} + {2'b00, lo} + {2'b00, cl};
    if (slot >= wlen) slot = 0;
    if (fill_cnt < wlen) fill_cnt++;
    else win_sum = win_sum - 42'(tp_win[slot]);
    tp_win[slot] = tp;
    win_sum = win_sum + 42'(tp);
    slot = (slot + 1 >= wlen) ? 0 : slot + 1;
    if (fill_cnt < wlen) return r;
    mean = win_sum / 42'(wlen);
    dsum = '0;
    for (int i = 0; i < wlen; i++) begin
      w = 42'(tp_win[i]);
      dsum += (w >= mean) ? 64'(w - mean) : 64'(mean - w);
    end
    md = dsum / 64'(wlen);
    r.ok = 1'b1;
    if (md == 0) return r;
    den = 128'(factor) * 128'(md);
    if (42'(tp) >= mean) begin
      num = 128'(42'(tp) - mean) << 32;
      q = num / den;
      r.value = (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    end else begin
      num = 128'(mean - 42'(tp)) << 32;
      q = num / den;
      r.value = (q >= 128'h80000000) ? 32'h80000000 : -q[31:0];
    end
    return r;
  endfunction

  task automatic write_reg(input logic idx, input logic [ccidx_pkg::CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == ccidx_pkg::CFG_WINDOW_LENGTH) begin
      wlen = data[ccidx_pkg::WLEN_W-1:0];
      if (wlen < 1) wlen = 1;
      if (wlen > WMAX) wlen = WMAX;
      win_sum = '0;
      fill_cnt = 0;
      slot = 0;
    end else begin
      factor = (data == 0) ? 1 : data;
    end
    @(posedge clk);
  endtask

  // Holds the word until it is taken; the caller decides whether valid drops.
  task automatic put_bar(input logic [31:0] hi, input logic [31:0] lo,
                         input logic [31:0] cl, input logic bv,
                         input logic typed, input cci_t typed_res);
    cci_t p;
    in_valid    <= 1'b1;
    high_price  <= hi;
    low_price   <= lo;
    close_price <= cl;
    bar_valid   <= bv;
    do @(posedge clk); while (in_stall);
    p = predict_cci(hi, lo, cl, bv);
    exp_fifo[exp_wr % EXP_DEPTH] = typed ? typed_res : p;
    exp_wr++;
  endtask

  task automatic idle_gap();
    int r;
    int g;
    r = $urandom_range(0, 99);
    g = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 150);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (exp_wr == exp_rd);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    bar_row_t   row;
    cci_t       tr;
    logic [31:0] base;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] cl;
    logic        bv;
    int          mode;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = ccidx_pkg::CFG_WINDOW_LENGTH;
    cfg_data = '0;
    in_valid = 1'b0;
    high_price = '0;
    low_price = '0;
    close_price = '0;
    bar_valid = 1'b0;
    win_sum = '0;
    fill_cnt = 0;
    slot = 0;
    wlen = 20;
    factor = ccidx_pkg::FACTOR_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      tr.value = row.ev;
      tr.ok = row.eok;
      put_bar(row.hi, row.lo, row.cl, row.bv, row.typed, tr);
      idle_gap();
    end
    drain();

    for (int p = 0; p < NPHASE; p++) begin
      write_reg(ccidx_pkg::CFG_WINDOW_LENGTH, ccidx_pkg::CFG_W'(ph_wlen[p]));
      write_reg(ccidx_pkg::CFG_CCI_FACTOR, ccidx_pkg::CFG_W'(ph_fac[p]));
      base = $urandom;
      for (int n = 0; n < ph_cnt[p]; n++) begin
        mode = $urandom_range(0, 99);
        bv = ($urandom_range(0, 99) >= 5);
        if (mode < 25) begin
          hi = $urandom;
          lo = $urandom;
          cl = $urandom;
        end else if (mode < 90) begin
          base = base + $urandom_range(0, 64) - 32;
          hi = base + $urandom_range(0, 255);
          lo = base - $urandom_range(0, 255);
          cl = base + $urandom_range(0, 127) - 64;
        end else begin
          hi = base;
          lo = base;
          cl = base;
        end
        put_bar(hi, lo, cl, bv, 1'b0, '0);
        if (!(p % 2 == 1 && n < 60)) begin
          idle_gap();
        end
      end
      drain();
    end
    sending_done = 1;
  end

  initial begin
    int r;
    bit held;
    held = 0;
    out_stall = 1'b0;
    forever begin
      if (!held && results >= 150) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r >= 65) begin
          out_stall <= 1'b1;
          repeat ((r < 96) ? $urandom_range(1, 4) : $urandom_range(20, 200)) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cci_t e;
    if (!rst && out_valid && !out_stall) begin
      results++;
      if (exp_wr == exp_rd) begin
        $display("%0t: unexpected word index_value=%h cci_valid=%b", $time, index_value,
                 cci_valid);
        errors++;
      end else begin
        e = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (index_value !== e.value) begin
          $display("%0t: index_value expected %h actual %h", $time, e.value, index_value);
          errors++;
        end
        if (cci_valid !== e.ok) begin
          $display("%0t: cci_valid expected %b actual %b", $time, e.ok, cci_valid);
          errors++;
        end
        if (e.ok) valid_results++;
        if (e.value == 32'h7FFFFFFF || e.value == 32'h80000000) saturated++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycles);
      $display("commodity_channel_index regression: fail");
      $finish;
    end
  end

  initial begin
    wait (sending_done);
    repeat (700) @(posedge clk);
    $display("Checked %0d result words, %0d of them valid and %0d saturated,", results,
             valid_results, saturated);
    $display("over %0d phases of window length and factor settings.", NPHASE + 1);
    if (errors == 0 && exp_wr == exp_rd) begin
      $display("commodity_channel_index regression: pass");
    end else begin
      $display("%0d mismatches, %0d words still awaited.", errors, exp_wr - exp_rd);
      $display("commodity_channel_index regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
sv/ccidx_pkg.sv
sv/ccidx_cell.sv
sv/ccidx_div.sv
sv/commodity_channel_index.sv
sv/ccidx_check.sv
sim/tb.sv
